FILE: sv/slab_overlay_memory_defines.svh
// Assertion macros shared by the slab overlay memory RTL.
`ifndef SLAB_OVERLAY_MEMORY_DEFINES_SVH
`define SLAB_OVERLAY_MEMORY_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SOM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slab overlay memory check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SOM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slab overlay memory check failed");

`endif

FILE: sv/som_pkg.sv
// Types, constants and font tables of the slab overlay memory.
`default_nettype none
package som_pkg;

    localparam int SLAB_SLOTS_DEF    = 16;
    localparam int PROGRAM_DEPTH_DEF = 2048;

    localparam logic [11:0] PROG_BASE         = 12'h200;
    localparam logic [11:0] PROGRAM_END_RESET = 12'd512;
    localparam logic [11:0] SMALL_FONT_END    = 12'd80;
    localparam logic [11:0] BIG_FONT_END      = 12'd240;
    localparam logic [7:0]  PAGE_FREE         = 8'h00;
    localparam logic [4:0]  SLAB_BYTES        = 5'd16;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_RDWAIT,
        ST_FILL,
        ST_STORE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic active;
        logic hit;
        logic free;
    } t_scan;

    localparam logic [7:0] SMALL_FONT [80] = '{
        8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
    };

    localparam logic [7:0] BIG_FONT [160] = '{
        8'hF0,8'hF0,8'h90,8'h90,8'h90,8'h90,8'h90,8'h90,8'hF0,8'hF0,
        8'h20,8'h60,8'h20,8'h20,8'h70, 8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h80,8'hF0,
        8'hF0,8'h10,8'hF0,8'h10,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10, 8'h90,8'h90,8'hF0,8'h10,8'h10,
        8'hF0,8'h80,8'hF0,8'h10,8'hF0, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h80,8'hF0,8'h90,8'hF0,
        8'hF0,8'h10,8'h20,8'h40,8'h40, 8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h90,8'hF0,
        8'hF0,8'h90,8'hF0,8'h10,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hF0,8'h90,8'hF0,8'h90,8'h90,
        8'hE0,8'h90,8'hE0,8'h90,8'hE0, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hF0,8'h80,8'h80,8'h80,8'hF0,
        8'hE0,8'h90,8'h90,8'h90,8'hE0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'hF0,
        8'hF0,8'h80,8'hF0,8'h80,8'h80, 8'hF0,8'h80,8'hF0,8'h80,8'h80
    };

    function automatic logic [7:0] font_byte(input logic [7:0] a);
        logic [7:0] b;
        b = a - 8'd80;
        if (a < 8'd80) begin
            return SMALL_FONT[a[6:0]];
        end else begin
            return BIG_FONT[b];
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/som_tag_cell.sv
// One slab tag cell of the search chain.
`default_nettype none
module som_tag_cell #(
    parameter int SLAB_SLOTS = som_pkg::SLAB_SLOTS_DEF,
    parameter int IDX        = 0,
    parameter int IW         = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [7:0]          i_page,
    input  som_pkg::t_scan      i_scan,
    input  wire  [IW-1:0]       i_idx,
    input  wire                 i_alloc,
    input  wire  [IW-1:0]       i_alloc_idx,
    output som_pkg::t_scan      o_scan,
    output logic [IW-1:0]       o_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [7:0]     r_tag;
    som_pkg::t_scan r_scan;
    som_pkg::t_scan n_scan;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  n_idx;

    always_comb begin
        n_scan = i_scan;
        n_idx  = i_idx;
        if (i_scan.active && !i_scan.hit &&
            (r_tag == i_page || r_tag == som_pkg::PAGE_FREE)) begin
            n_scan.hit  = 1'b1;
            n_scan.free = (r_tag == som_pkg::PAGE_FREE);
            n_idx       = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= som_pkg::PAGE_FREE;
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_alloc && i_alloc_idx == MY_IDX) begin
                r_tag <= i_page;
            end
        end
        r_idx <= n_idx;
    end

    assign o_scan = r_scan;
    assign o_idx  = r_idx;

endmodule
`default_nettype wire

FILE: sv/slab_overlay_memory.sv
// Top level of the slab overlay memory: control, byte memories and tag chain.
// Usage: command beats enter on s_axis (tdata: cmd, address, wdata); one
// response beat per command leaves on m_axis (tdata: read_data, status,
// halted). The user must write the program end register through i_cfg_we and
// i_cfg_wdata only while no command is in flight; the block does not enforce it.
// One command is in work at a time. Reads and slab hits wait for the page
// search, which walks the tag cell chain one cell per cycle. A write that
// claims a free slab then does the sixteen-byte fill through the single
// program memory read port. Loads, dropped writes and unused commands go
// straight from decode to the response.
// The response register is separate from the work logic, so a new command
// is taken while a response waits; a stalled receiver holds the response
// and the next command waits at the end of its work.
// Reset frees all slabs, clears the halt flag and sets the program end to
// 0x200. Slab and program bytes are undefined until written.
`default_nettype none
module slab_overlay_memory #(
    parameter int SLAB_SLOTS    = som_pkg::SLAB_SLOTS_DEF,
    parameter int PROGRAM_DEPTH = som_pkg::PROGRAM_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // cmd[1:0], address[13:2], wdata[21:14]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_data[7:0], status[9:8], halted[10]
    input  wire         i_cfg_we,
    input  wire  [11:0] i_cfg_wdata
);

    localparam int IW = (SLAB_SLOTS > 1) ? $clog2(SLAB_SLOTS) : 1;
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int SLAB_DEPTH = SLAB_SLOTS * 16;
    localparam logic [12:0] PROG_DEPTH13 = 13'(PROGRAM_DEPTH);

    som_pkg::t_state r_state;
    som_pkg::t_state n_state;

    logic [11:0]   r_prog_end;
    logic [1:0]    r_cmd;
    logic [11:0]   r_addr;
    logic [7:0]    r_wdata;
    logic          r_halt;
    logic          n_halt;
    logic [7:0]    r_rd;
    logic [7:0]    n_rd;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_src_slab;
    logic          n_src_slab;
    logic [IW-1:0] r_sidx;
    logic [IW-1:0] n_sidx;
    logic [4:0]    r_cnt;
    logic [4:0]    n_cnt;
    logic          r_fill_ok;
    logic          n_fill_ok;
    logic          r_out_valid;
    logic [15:0]   r_out_data;
    logic          out_load;

    logic [7:0] r_slab_mem [SLAB_DEPTH];
    logic [7:0] r_prog_mem [PROGRAM_DEPTH];
    logic [7:0] r_slab_q;
    logic [7:0] r_prog_q;

    logic          slab_we;
    logic [IW+3:0] slab_waddr;
    logic [7:0]    slab_wdata;
    logic [IW+3:0] slab_raddr;
    logic          prog_we;
    logic [PW-1:0] prog_waddr;
    logic [PW-1:0] prog_raddr;

    som_pkg::t_scan scan [SLAB_SLOTS+1];
    logic [IW-1:0]  sidx [SLAB_SLOTS+1];
    logic           scan_start;
    logic           alloc;

    logic [12:0] cur_off;
    logic [11:0] fill_addr;
    logic [12:0] fill_off;
    logic [4:0]  cnt_m1;
    logic        cur_in_store;
    logic        cur_readable;
    logic        fill_readable;

    assign cur_off      = {1'b0, r_addr} - {1'b0, som_pkg::PROG_BASE};
    assign fill_addr    = {r_addr[11:4], r_cnt[3:0]};
    assign fill_off     = {1'b0, fill_addr} - {1'b0, som_pkg::PROG_BASE};
    assign cnt_m1       = r_cnt - 5'd1;
    assign cur_in_store = (r_addr >= som_pkg::PROG_BASE) && (cur_off < PROG_DEPTH13);
    assign cur_readable = cur_in_store && (r_addr < r_prog_end);
    assign fill_readable = (fill_addr >= som_pkg::PROG_BASE) && (fill_off < PROG_DEPTH13)
                           && (fill_addr < r_prog_end);

    assign scan[0] = '{active: scan_start, hit: 1'b0, free: 1'b0};
    assign sidx[0] = '0;

    for (genvar g = 0; g < SLAB_SLOTS; g++) begin : g_cell
        som_tag_cell #(
            .SLAB_SLOTS (SLAB_SLOTS),
            .IDX        (g),
            .IW         (IW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_page      (r_addr[11:4]),
            .i_scan      (scan[g]),
            .i_idx       (sidx[g]),
            .i_alloc     (alloc),
            .i_alloc_idx (r_sidx),
            .o_scan      (scan[g+1]),
            .o_idx       (sidx[g+1])
        );
    end

    always_comb begin
        n_state       = r_state;
        n_halt        = r_halt;
        n_rd          = r_rd;
        n_status      = r_status;
        n_src_slab    = r_src_slab;
        n_sidx        = r_sidx;
        n_cnt         = r_cnt;
        n_fill_ok     = r_fill_ok;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        scan_start    = 1'b0;
        alloc         = 1'b0;
        slab_we       = 1'b0;
        slab_waddr    = {r_sidx, r_addr[3:0]};
        slab_wdata    = r_wdata;
        slab_raddr    = {sidx[SLAB_SLOTS], r_addr[3:0]};
        prog_we       = 1'b0;
        prog_waddr    = cur_off[PW-1:0];
        prog_raddr    = cur_off[PW-1:0];
        case (r_state)
            som_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = som_pkg::ST_DECODE;
                end
            end
            som_pkg::ST_DECODE: begin
                n_rd     = 8'd0;
                n_status = som_pkg::STATUS_OK;
                n_state  = som_pkg::ST_RESP;
                if (r_cmd == som_pkg::CMD_READ ||
                    (r_cmd == som_pkg::CMD_WRITE && r_addr[11:4] != som_pkg::PAGE_FREE)) begin
                    scan_start = 1'b1;
                    n_state    = som_pkg::ST_SEARCH;
                end else if (r_cmd == som_pkg::CMD_LOAD) begin
                    prog_we = cur_in_store;
                end
            end
            som_pkg::ST_SEARCH: begin
                if (scan[SLAB_SLOTS].active) begin
                    n_sidx  = sidx[SLAB_SLOTS];
                    n_state = som_pkg::ST_RESP;
                    if (r_cmd == som_pkg::CMD_READ) begin
                        if (scan[SLAB_SLOTS].hit && !scan[SLAB_SLOTS].free) begin
                            n_src_slab = 1'b1;
                            n_state    = som_pkg::ST_RDWAIT;
                        end else if (r_addr < som_pkg::BIG_FONT_END) begin
                            n_rd = som_pkg::font_byte(r_addr[7:0]);
                        end else if (cur_readable) begin
                            n_src_slab = 1'b0;
                            n_state    = som_pkg::ST_RDWAIT;
                        end else begin
                            n_status = som_pkg::STATUS_UNMAPPED;
                            n_halt   = 1'b1;
                        end
                    end else if (!scan[SLAB_SLOTS].hit) begin
                        n_status = som_pkg::STATUS_FULL;
                        n_halt   = 1'b1;
                    end else if (scan[SLAB_SLOTS].free) begin
                        n_cnt   = 5'd0;
                        n_state = som_pkg::ST_FILL;
                    end else begin
                        slab_we    = 1'b1;
                        slab_waddr = {sidx[SLAB_SLOTS], r_addr[3:0]};
                    end
                end
            end
            som_pkg::ST_RDWAIT: begin
                n_rd    = r_src_slab ? r_slab_q : r_prog_q;
                n_state = som_pkg::ST_RESP;
            end
            som_pkg::ST_FILL: begin
                prog_raddr = fill_off[PW-1:0];
                n_fill_ok  = fill_readable;
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == 5'd0) begin
                    alloc = 1'b1;
                end else begin
                    slab_we    = 1'b1;
                    slab_waddr = {r_sidx, cnt_m1[3:0]};
                    slab_wdata = r_fill_ok ? r_prog_q : 8'd0;
                end
                if (r_cnt == som_pkg::SLAB_BYTES) begin
                    n_state = som_pkg::ST_STORE;
                end
            end
            som_pkg::ST_STORE: begin
                slab_we = 1'b1;
                n_state = som_pkg::ST_RESP;
            end
            som_pkg::ST_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = som_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = som_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= som_pkg::ST_IDLE;
            r_halt      <= 1'b0;
            r_prog_end  <= som_pkg::PROGRAM_END_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_halt  <= n_halt;
            if (i_cfg_we) begin
                r_prog_end <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd   <= s_axis_tdata[1:0];
            r_addr  <= s_axis_tdata[13:2];
            r_wdata <= s_axis_tdata[21:14];
        end
        if (out_load) begin
            r_out_data <= {5'd0, r_halt, r_status, r_rd};
        end
        r_rd       <= n_rd;
        r_status   <= n_status;
        r_src_slab <= n_src_slab;
        r_sidx     <= n_sidx;
        r_cnt      <= n_cnt;
        r_fill_ok  <= n_fill_ok;
    end

    always_ff @(posedge i_clk) begin
        if (slab_we) begin
            r_slab_mem[slab_waddr] <= slab_wdata;
        end
        r_slab_q <= r_slab_mem[slab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            r_prog_mem[prog_waddr] <= r_wdata;
        end
        r_prog_q <= r_prog_mem[prog_raddr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "slab_overlay_memory_defines.svh"

    `SOM_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt)
    `SOM_ASSERT_NOW(a_fault_halts, m_axis_tvalid && m_axis_tdata[9:8] != som_pkg::STATUS_OK,
                    m_axis_tdata[10])
    `SOM_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SOM_ASSERT_NOW(a_fill_has_slot, r_state == som_pkg::ST_FILL, r_cnt <= som_pkg::SLAB_BYTES)

endmodule
`default_nettype wire
